### hdl/spq_pkg.sv
package spq_pkg;

  // Request codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // One stored entry
  typedef struct packed {
    logic signed [31:0] data;
    logic signed [15:0] prio;
  } entry_t;

  // Broadcast control to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } ctl_t;

endpackage

### hdl/spq_cell.sv
module spq_cell (
  input  logic           clk,
  input  spq_pkg::ctl_t   ctl,
  input  logic           occupied,
  input  logic           left_keep,
  input  spq_pkg::entry_t left_entry,
  input  spq_pkg::entry_t right_entry,
  output spq_pkg::entry_t entry,
  output logic           keep
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // Keep position when holding a strictly higher priority than the new word
  assign keep = occupied && (entry_r.prio > ctl.item.prio);

  // Pick next content: hold, take new word, shift down from left, or up from right
  always_comb begin
    entry_nxt = entry_r;
    priority if (ctl.enq) begin
      if (left_keep) begin
        entry_nxt = keep ? entry_r : ctl.item;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctl.deq) begin
      entry_nxt = right_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

### hdl/sorted_priority_queue.sv
// Sorted priority queue of DEPTH entries held in a chain of cells, highest
// priority at the head, ties served newest first. Every request word gives one
// result word in the cycle after it is accepted; a new request is taken in every
// cycle in which the result register is empty or being drained, since each
// cell updates from itself and its two neighbors at once. A full
// enqueue or an empty dequeue returns an error status and leaves the store
// unchanged.
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_req_type,
  input  logic signed [31:0] in_item_data,
  input  logic signed [15:0] in_item_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic signed [15:0] out_priority,
  output logic [4:0]         out_occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic [1:0]    status_r, status_nxt;
  logic signed [31:0] data_r, data_nxt;
  logic signed [15:0] prio_r, prio_nxt;
  logic [4:0]    occ_r;

  logic   accept;
  logic   is_full, is_empty;
  ctl_t   ctl;
  entry_t cell_entry [DEPTH];
  logic   cell_keep  [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  // Broadcast the accepted request to the chain
  always_comb begin
    ctl.enq       = accept && (in_req_type == REQ_ENQ) && !is_full;
    ctl.deq       = accept && (in_req_type == REQ_DEQ) && !is_empty;
    ctl.item.data = in_item_data;
    ctl.item.prio = in_item_priority;
  end

  // Build the chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic   occ;
    logic   lkeep;
    entry_t lent, rent;

    assign occ = (count_r > IDX);
    if (i == 0) begin : g_head
      assign lkeep = 1'b1;
      assign lent  = cell_entry[0];
    end else begin : g_body
      assign lkeep = cell_keep[i-1];
      assign lent  = cell_entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign rent = cell_entry[i];
    end else begin : g_mid
      assign rent = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ),
      .left_keep   (lkeep),
      .left_entry  (lent),
      .right_entry (rent),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  // Form the result word and the next count
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_ENQUEUED;
    data_nxt   = '0;
    prio_nxt   = '0;
    unique case (in_req_type)
      REQ_ENQ: begin
        if (is_full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_ENQUEUED;
          count_nxt  = count_r + CW'(1);
        end
      end
      REQ_DEQ: begin
        if (is_empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          status_nxt = ST_DEQUEUED;
          data_nxt   = cell_entry[0].data;
          prio_nxt   = cell_entry[0].prio;
          count_nxt  = count_r - CW'(1);
        end
      end
      default: status_nxt = ST_ENQUEUED;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      data_r   <= data_nxt;
      prio_r   <= prio_nxt;
      occ_r    <= 5'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_data      = data_r;
  assign out_priority  = prio_r;
  assign out_occupancy = occ_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond depth");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == REQ_ENQ && !is_full) |=> count_r == $past(count_r) + CW'(1))
    else $error("enqueue did not advance count");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> occ_r == 5'(FULL_CNT))
    else $error("full status with wrong occupancy");
`endif

endmodule
